// ===== rtl/core/mnsm_pkg.sv =====
// mnsm_pkg: shared sizes, message codes and controller/datapath interface types
// for the midi note state matrix; no dependencies
package mnsm_pkg;

  // table dimensions
  localparam int CHANNELS   = 16;
  localparam int NOTES      = 128;
  localparam int COUNT_BITS = 8;

  localparam int DEPTH    = CHANNELS * NOTES;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int COUNT_TOP  = (1 << COUNT_BITS) - 1;
  localparam int CHAN_TOT_W = $clog2(NOTES * COUNT_TOP + 1);
  localparam int GRAND_W    = $clog2(CHANNELS * NOTES * COUNT_TOP + 1);

  // fixed field widths
  localparam int STATUS_W = 8;
  localparam int DATA_W   = 7;
  localparam int KIND_W   = 4;
  localparam int CHAN_W   = 4;
  localparam int NOTE_OUT_W  = 8;
  localparam int CHAN_OUT_W  = 15;
  localparam int TOTAL_OUT_W = 19;

  // midi message kinds (status high nibble)
  localparam logic [KIND_W-1:0] KIND_NOTE_OFF = 4'h8;
  localparam logic [KIND_W-1:0] KIND_NOTE_ON  = 4'h9;
  localparam logic [KIND_W-1:0] KIND_CTRL     = 4'hB;

  // controller numbers
  localparam logic [DATA_W-1:0] CC_DAMPER  = 7'd64;
  localparam logic [DATA_W-1:0] CC_ALL_OFF = 7'd123;
  localparam int DAMPER_BIT = 6;

  // how the controller must treat an incoming item
  typedef enum logic [1:0] {
    CLS_EXEC,
    CLS_ALL_OFF,
    CLS_CLEAR_ALL
  } item_class_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load_item;
    logic sweep_start_all;
    logic sweep_start_chan;
    logic sweep_step;
    logic exec;
    logic finish_clear;
  } ctrl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    item_class_t cls;
    logic        sweep_done;
    logic        out_free;
  } dp_status_t;

endpackage

// ===== rtl/core/mnsm_ctrl.sv =====
// mnsm_ctrl: sequencing state machine for the note state matrix
// depends on mnsm_pkg for command and status types
module mnsm_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mnsm_pkg::dp_status_t  status,
  output mnsm_pkg::ctrl_cmd_t   cmd
);
  import mnsm_pkg::*;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_EXEC,
    ST_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   report;
  logic   report_next;
  logic   accept;

  assign accept = in_valid && in_ready;

  // next state and commands
  always_comb begin
    state_next  = state;
    report_next = report;
    cmd         = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.load_item = 1'b1;
          case (status.cls)
            CLS_CLEAR_ALL: begin
              cmd.sweep_start_all = 1'b1;
              report_next         = 1'b1;
              state_next          = ST_SWEEP;
            end
            CLS_ALL_OFF: begin
              cmd.sweep_start_chan = 1'b1;
              report_next          = 1'b1;
              state_next           = ST_SWEEP;
            end
            default: begin
              state_next = ST_EXEC;
            end
          endcase
        end
      end
      ST_EXEC: begin
        if (status.out_free) begin
          cmd.exec   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (status.sweep_done) begin
          state_next = report ? ST_FINISH : ST_IDLE;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.finish_clear = 1'b1;
          report_next      = 1'b0;
          state_next       = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state and registered ready; reset starts the table clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_SWEEP;
      report   <= 1'b0;
      in_ready <= 1'b0;
    end else begin
      state    <= state_next;
      report   <= report_next;
      in_ready <= (state_next == ST_IDLE);
    end
  end

endmodule

// ===== rtl/core/mnsm_datapath.sv =====
// mnsm_datapath: count memory, totals, damper flags, sweep counter and
// output register; depends on mnsm_pkg
module mnsm_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_op,
  input  logic [mnsm_pkg::STATUS_W-1:0]        in_status,
  input  logic [mnsm_pkg::DATA_W-1:0]          in_data_one,
  input  logic [mnsm_pkg::DATA_W-1:0]          in_data_two,
  input  mnsm_pkg::ctrl_cmd_t                  cmd,
  output mnsm_pkg::dp_status_t                 status,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic                                 out_handled,
  output logic [mnsm_pkg::NOTE_OUT_W-1:0]      out_note_count,
  output logic [mnsm_pkg::CHAN_OUT_W-1:0]      out_channel_notes,
  output logic [mnsm_pkg::TOTAL_OUT_W-1:0]     out_total_notes,
  output logic                                 out_pedal_down
);
  import mnsm_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // storage
  logic [COUNT_BITS-1:0] mem [DEPTH];
  logic [COUNT_BITS-1:0] rd_data;
  logic [CHAN_TOT_W-1:0] chan_tot [CHANNELS];
  logic [GRAND_W-1:0]    grand;
  logic [CHANNELS-1:0]   damper;

  // latched item
  logic                  item_op;
  logic [KIND_W-1:0]     item_kind;
  logic [CHAN_W-1:0]     item_ch;
  logic [DATA_W-1:0]     item_d1;
  logic [DATA_W-1:0]     item_d2;
  logic [ADDR_W-1:0]     item_addr;

  // sweep counter
  logic [ADDR_W-1:0]     sweep_addr;
  logic [ADDR_W-1:0]     sweep_last;

  // incoming item decode
  logic [KIND_W-1:0]     in_kind;
  logic [CHAN_W-1:0]     in_ch;
  logic                  in_ch_ok;
  logic [ADDR_W-1:0]     in_addr;
  logic [ADDR_W-1:0]     in_base;

  // update terms
  logic [CH_IDX_W-1:0]   ch_idx;
  logic                  ch_ok;
  logic                  note_ok;
  logic                  is_on;
  logic                  is_note;
  logic                  inc;
  logic                  dec;
  logic                  damper_wr;
  logic [COUNT_BITS-1:0] new_cnt;
  logic [CHAN_TOT_W-1:0] cur_tot;
  logic [CHAN_TOT_W-1:0] tot_next;
  logic [GRAND_W-1:0]    grand_next;
  logic [GRAND_W-1:0]    clr_grand;
  logic                  flag_next;

  // classify the item at the input
  always_comb begin
    in_kind  = in_status[STATUS_W-1 -: KIND_W];
    in_ch    = in_status[CHAN_W-1:0];
    in_ch_ok = int'(in_ch) < CHANNELS;
    in_addr  = ADDR_W'(int'(in_ch) * NOTES + int'(in_data_one));
    in_base  = ADDR_W'(int'(in_ch) * NOTES);
    if (in_op) begin
      status.cls = CLS_CLEAR_ALL;
    end else if (in_ch_ok && in_kind == KIND_CTRL && in_data_one == CC_ALL_OFF) begin
      status.cls = CLS_ALL_OFF;
    end else begin
      status.cls = CLS_EXEC;
    end
    status.sweep_done = (sweep_addr == sweep_last);
    status.out_free   = !out_valid || out_ready;
  end

  // read-modify-write terms for the latched item
  always_comb begin
    ch_idx    = item_ch[CH_IDX_W-1:0];
    ch_ok     = int'(item_ch) < CHANNELS;
    note_ok   = int'(item_d1) < NOTES;
    cur_tot   = chan_tot[ch_idx];
    is_on     = (item_kind == KIND_NOTE_ON) && (item_d2 != '0);
    is_note   = ch_ok && note_ok &&
                ((item_kind == KIND_NOTE_ON) || (item_kind == KIND_NOTE_OFF));
    inc       = is_note && is_on && (rd_data != COUNT_MAX);
    dec       = is_note && !is_on && (rd_data != '0);
    damper_wr = ch_ok && (item_kind == KIND_CTRL) && (item_d1 == CC_DAMPER);
    new_cnt   = rd_data;
    tot_next  = cur_tot;
    grand_next = grand;
    if (inc) begin
      new_cnt    = rd_data + COUNT_BITS'(1);
      tot_next   = cur_tot + CHAN_TOT_W'(1);
      grand_next = grand + GRAND_W'(1);
    end else if (dec) begin
      new_cnt    = rd_data - COUNT_BITS'(1);
      tot_next   = cur_tot - CHAN_TOT_W'(1);
      grand_next = grand - GRAND_W'(1);
    end
    flag_next = damper_wr ? item_d2[DAMPER_BIT] : damper[ch_idx];
    clr_grand = item_op ? '0 : grand - GRAND_W'(cur_tot);
  end

  // count memory: one write port, registered read
  always_ff @(posedge clk) begin
    if (cmd.sweep_step) begin
      mem[sweep_addr] <= '0;
    end else if (cmd.exec && (inc || dec)) begin
      mem[item_addr] <= new_cnt;
    end
    if (cmd.load_item) begin
      rd_data <= mem[in_addr];
    end
  end

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_op   <= in_op;
      item_kind <= in_kind;
      item_ch   <= in_ch;
      item_d1   <= in_data_one;
      item_d2   <= in_data_two;
      item_addr <= in_addr;
    end
  end

  // totals, flags, sweep counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        chan_tot[c] <= '0;
      end
      grand      <= '0;
      damper     <= '0;
      sweep_addr <= '0;
      sweep_last <= ADDR_W'(DEPTH - 1);
      out_valid  <= 1'b0;
    end else begin
      // sweep range setup and stepping
      if (cmd.sweep_start_all) begin
        sweep_addr <= '0;
        sweep_last <= ADDR_W'(DEPTH - 1);
      end else if (cmd.sweep_start_chan) begin
        sweep_addr <= in_base;
        sweep_last <= ADDR_W'(int'(in_base) + NOTES - 1);
      end else if (cmd.sweep_step && !status.sweep_done) begin
        sweep_addr <= sweep_addr + ADDR_W'(1);
      end
      // note and damper update
      if (cmd.exec) begin
        if (inc || dec) begin
          chan_tot[ch_idx] <= tot_next;
          grand            <= grand_next;
        end
        if (damper_wr) begin
          damper[ch_idx] <= flag_next;
        end
      end
      // channel or full clear after its sweep
      if (cmd.finish_clear) begin
        if (item_op) begin
          for (int c = 0; c < CHANNELS; c++) begin
            chan_tot[c] <= '0;
          end
          damper <= '0;
        end else begin
          chan_tot[ch_idx] <= '0;
          damper[ch_idx]   <= 1'b0;
        end
        grand <= clr_grand;
      end
      // output slot
      if (cmd.exec || cmd.finish_clear) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_handled       <= is_note;
      out_note_count    <= (ch_ok && note_ok) ? NOTE_OUT_W'(new_cnt) : '0;
      out_channel_notes <= ch_ok ? CHAN_OUT_W'(tot_next) : '0;
      out_total_notes   <= TOTAL_OUT_W'(grand_next);
      out_pedal_down    <= ch_ok && flag_next;
    end else if (cmd.finish_clear) begin
      out_handled       <= 1'b1;
      out_note_count    <= '0;
      out_channel_notes <= '0;
      out_total_notes   <= TOTAL_OUT_W'(clr_grand);
      out_pedal_down    <= 1'b0;
    end
  end

endmodule

// ===== rtl/core/midi_note_state_matrix.sv =====
// midi_note_state_matrix: top level, joins controller and datapath and packs
// the stream buses; depends on mnsm_pkg, mnsm_ctrl, mnsm_datapath
//
// Usage:
//   s_axis carries one complete midi channel message (or a clear-all command
//   in tuser) per transaction; m_axis returns exactly one result per item.
//   A note, damper or ignored message is accepted in ST_IDLE, where the count
//   memory is read; in ST_EXEC, once the output register is free, the count,
//   channel total and grand total are updated and the result is loaded into
//   the output register, which drives m_axis_tvalid. No new item is taken
//   until the controller is back in ST_IDLE.
//   All-notes-off sweeps the channel's 128 count entries through the single
//   memory write port, one per cycle.
//   Clear-all sweeps all 2048 entries the same way.
//   After reset the block clears all 2048 count entries in a sweep with
//   s_axis_tready low; totals and damper flags clear at once.
//   When m_axis_tready is low the result waits in the output register; the
//   block may take the next item, but holds its result until the slot frees.
module midi_note_state_matrix (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // status_byte[7:0], data_one[14:8], data_two[21:15], zeros
  input  logic        s_axis_tuser,  // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // note_count[7:0], channel_notes[22:8],
                                     // total_notes[41:23], pedal_down[42], zeros
  output logic        m_axis_tuser   // handled
);
  import mnsm_pkg::*;

  ctrl_cmd_t              cmd;
  dp_status_t             status;
  logic [NOTE_OUT_W-1:0]  note_count;
  logic [CHAN_OUT_W-1:0]  channel_notes;
  logic [TOTAL_OUT_W-1:0] total_notes;
  logic                   pedal_down;

  mnsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mnsm_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .in_op             (s_axis_tuser),
    .in_status         (s_axis_tdata[7:0]),
    .in_data_one       (s_axis_tdata[14:8]),
    .in_data_two       (s_axis_tdata[21:15]),
    .cmd               (cmd),
    .status            (status),
    .out_ready         (m_axis_tready),
    .out_valid         (m_axis_tvalid),
    .out_handled       (m_axis_tuser),
    .out_note_count    (note_count),
    .out_channel_notes (channel_notes),
    .out_total_notes   (total_notes),
    .out_pedal_down    (pedal_down)
  );

  // result packing, lowest field first
  assign m_axis_tdata = {5'b0, pedal_down, total_notes, channel_notes, note_count};

endmodule

// ===== rtl/core/mnsm_checker.sv =====
// mnsm_checker: port-level assertions for midi_note_state_matrix, bound to
// the top level; no package dependency
module mnsm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [23:0] s_axis_tdata,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // reset starts the clearing sweep with input closed
  a_reset_sweep: assert property (@(posedge clk)
    rst |=> !s_axis_tready)
    else $error("input open right after reset");

  // one item at a time: ready drops after each transaction
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in work");

  // a channel total never exceeds the grand total
  a_chan_le_total: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ({4'b0, m_axis_tdata[22:8]} <= m_axis_tdata[41:23]))
    else $error("channel total above grand total");

  // a note count never exceeds its channel total
  a_note_le_chan: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ({7'b0, m_axis_tdata[7:0]} <= m_axis_tdata[22:8]))
    else $error("note count above channel total");

endmodule

bind midi_note_state_matrix mnsm_checker u_mnsm_checker (.*);

// ===== test/testbench.sv =====
// testbench: self-checking stream test of midi_note_state_matrix, drives midi
// messages and clear-all commands and checks every result against a predictor
// depends on mnsm_pkg and the midi_note_state_matrix rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mnsm_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_ITEMS = 1360;
  localparam int SAT_BURST = 262;

  // one result as the block reports it
  typedef struct packed {
    logic                   handled;
    logic [NOTE_OUT_W-1:0]  note_count;
    logic [CHAN_OUT_W-1:0]  channel_notes;
    logic [TOTAL_OUT_W-1:0] total_notes;
    logic                   pedal_down;
  } note_report_t;

  // predictor of the note matrix plus the queue of reports still due
  class note_matrix_sb;
    logic [COUNT_BITS-1:0] counts [CHANNELS][NOTES];
    logic [CHAN_TOT_W-1:0] chan_sum [CHANNELS];
    logic [GRAND_W-1:0]    grand;
    bit                    damper [CHANNELS];
    note_report_t          reports_due [$];
    int                    mismatches;

    function new();
      mismatches = 0;
      wipe_all();
    endfunction

    function void wipe_all();
      for (int c = 0; c < CHANNELS; c++) begin
        for (int n = 0; n < NOTES; n++) counts[c][n] = '0;
        chan_sum[c] = '0;
        damper[c] = 1'b0;
      end
      grand = '0;
    endfunction

    // apply one accepted transaction and queue the report it must produce
    function void note_input(logic op, logic [STATUS_W-1:0] status,
                             logic [DATA_W-1:0] d1, logic [DATA_W-1:0] d2);
      logic [KIND_W-1:0] kind;
      int ch;
      note_report_t rep;
      kind = status[7:4];
      ch = int'(status[3:0]);
      rep.handled = 1'b0;
      if (op) begin
        wipe_all();
        rep.handled = 1'b1;
      end else if (kind == KIND_CTRL) begin
        if (d1 == CC_ALL_OFF) begin
          for (int n = 0; n < NOTES; n++) counts[ch][n] = '0;
          grand = grand - chan_sum[ch];
          chan_sum[ch] = '0;
          damper[ch] = 1'b0;
          rep.handled = 1'b1;
        end else if (d1 == CC_DAMPER) begin
          damper[ch] = d2[DAMPER_BIT];
        end
      end else if (kind == KIND_NOTE_ON || kind == KIND_NOTE_OFF) begin
        if (kind == KIND_NOTE_ON && d2 != '0) begin
          // saturated entries stay put but the message still counts as handled
          if (counts[ch][d1] != COUNT_TOP) begin
            counts[ch][d1]++;
            chan_sum[ch]++;
            grand++;
          end
        end else if (counts[ch][d1] != '0) begin
          counts[ch][d1]--;
          chan_sum[ch]--;
          grand--;
        end
        rep.handled = 1'b1;
      end
      rep.note_count = counts[ch][d1];
      rep.channel_notes = chan_sum[ch];
      rep.total_notes = grand;
      rep.pedal_down = damper[ch];
      reports_due.push_back(rep);
    endfunction

    // compare one result transaction with the oldest report due
    function void check_report(logic [47:0] data, logic handled);
      note_report_t want;
      note_report_t got;
      got.handled = handled;
      got.note_count = data[7:0];
      got.channel_notes = data[22:8];
      got.total_notes = data[41:23];
      got.pedal_down = data[42];
      if (reports_due.size() == 0) begin
        $error("unexpected result transaction: data %h handled %0d", data, handled);
        mismatches++;
        return;
      end
      want = reports_due.pop_front();
      if (got.handled !== want.handled) begin
        $error("handled: expected %0d, actual %0d", want.handled, got.handled);
        mismatches++;
      end
      if (got.note_count !== want.note_count) begin
        $error("note_count: expected %0d, actual %0d", want.note_count, got.note_count);
        mismatches++;
      end
      if (got.channel_notes !== want.channel_notes) begin
        $error("channel_notes: expected %0d, actual %0d",
               want.channel_notes, got.channel_notes);
        mismatches++;
      end
      if (got.total_notes !== want.total_notes) begin
        $error("total_notes: expected %0d, actual %0d", want.total_notes, got.total_notes);
        mismatches++;
      end
      if (got.pedal_down !== want.pedal_down) begin
        $error("pedal_down: expected %0d, actual %0d", want.pedal_down, got.pedal_down);
        mismatches++;
      end
    endfunction

    function int waiting();
      return reports_due.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;

  note_matrix_sb sb = new();
  bit calm = 1'b0;   // no idling on either side while set
  int cycles = 0;
  logic [DATA_W-1:0] hot_base = '0;

  midi_note_state_matrix u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk = ~clk;

  // cycle budget, covers the clear sweeps with a wide margin
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // result side: check accepted transactions, then pick next tready
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_report(m_axis_tdata, m_axis_tuser);
    m_axis_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 19);
  end

  // present one item, with random idle cycles ahead of it
  task automatic send_item(input logic op, input logic [STATUS_W-1:0] status,
                           input logic [DATA_W-1:0] d1, input logic [DATA_W-1:0] d2);
    while (!calm && $urandom_range(0, 99) < 19) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, d2, d1, status};
    s_axis_tuser <= op;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(op, status, d1, d2);
  endtask

  // hold off the sender until every report due has arrived
  task automatic drain_reports();
    s_axis_tvalid <= 1'b0;
    while (sb.waiting() != 0) @(posedge clk);
  endtask

  // mostly well-formed messages on a few hot notes, some noise
  task automatic send_random_item();
    int r;
    logic [CHAN_W-1:0] ch;
    logic [DATA_W-1:0] note;
    logic [DATA_W-1:0] vel;
    r = int'($urandom_range(0, 99));
    ch = CHAN_W'($urandom_range(0, 15));
    note = ($urandom_range(0, 9) < 7) ? hot_base + DATA_W'($urandom_range(0, 7))
                                      : DATA_W'($urandom_range(0, 127));
    vel = ($urandom_range(0, 9) == 0) ? '0 : DATA_W'($urandom_range(1, 127));
    if (r < 1)
      send_item(1'b1, STATUS_W'($urandom_range(0, 255)), DATA_W'($urandom_range(0, 127)),
                DATA_W'($urandom_range(0, 127)));
    else if (r < 46)
      send_item(1'b0, {KIND_NOTE_ON, ch}, note, vel);
    else if (r < 70)
      send_item(1'b0, {KIND_NOTE_OFF, ch}, note, DATA_W'($urandom_range(0, 127)));
    else if (r < 74)
      send_item(1'b0, {KIND_CTRL, ch}, CC_ALL_OFF, DATA_W'($urandom_range(0, 127)));
    else if (r < 82)
      send_item(1'b0, {KIND_CTRL, ch}, CC_DAMPER, DATA_W'($urandom_range(0, 127)));
    else if (r < 87)
      send_item(1'b0, {KIND_CTRL, ch}, DATA_W'($urandom_range(0, 127)),
                DATA_W'($urandom_range(0, 127)));
    else
      send_item(1'b0, STATUS_W'($urandom_range(0, 255)), DATA_W'($urandom_range(0, 127)),
                DATA_W'($urandom_range(0, 127)));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: note on/off at the field extremes, floor at zero
    send_item(1'b0, {KIND_NOTE_ON, 4'h0}, 7'd0, 7'd1);
    send_item(1'b0, {KIND_NOTE_ON, 4'h0}, 7'd0, 7'd127);
    send_item(1'b0, {KIND_NOTE_ON, 4'hF}, 7'd127, 7'd127);
    send_item(1'b0, {KIND_NOTE_OFF, 4'h0}, 7'd0, 7'd0);
    send_item(1'b0, {KIND_NOTE_ON, 4'h0}, 7'd0, 7'd0);
    send_item(1'b0, {KIND_NOTE_OFF, 4'h0}, 7'd0, 7'd64);
    send_item(1'b0, {KIND_NOTE_OFF, 4'hF}, 7'd127, 7'd127);
    // damper flag from value bit 6, other controllers ignored
    send_item(1'b0, {KIND_NOTE_ON, 4'h3}, 7'd64, 7'd64);
    send_item(1'b0, {KIND_CTRL, 4'h3}, CC_DAMPER, 7'h40);
    send_item(1'b0, {KIND_CTRL, 4'h3}, CC_DAMPER, 7'h3F);
    send_item(1'b0, {KIND_CTRL, 4'h3}, CC_DAMPER, 7'h7F);
    send_item(1'b0, {KIND_CTRL, 4'h3}, 7'd7, 7'd100);
    send_item(1'b0, {KIND_CTRL, 4'h3}, CC_ALL_OFF, 7'd0);
    // non-channel and unsupported kinds change nothing
    send_item(1'b0, 8'h00, 7'd127, 7'd127);
    send_item(1'b0, 8'h7F, 7'd0, 7'd0);
    send_item(1'b0, 8'hF0, 7'd64, 7'd64);
    send_item(1'b0, 8'hFF, CC_ALL_OFF, 7'd127);
    send_item(1'b0, 8'hA2, 7'd64, 7'd64);
    send_item(1'b0, 8'hC2, 7'd64, 7'd64);
    send_item(1'b0, 8'hE2, 7'd127, 7'd127);
    // all-notes-off on the top channel, then clear-all with live fields
    send_item(1'b0, {KIND_NOTE_ON, 4'h9}, 7'd10, 7'd90);
    send_item(1'b0, {KIND_CTRL, 4'hF}, CC_ALL_OFF, 7'd127);
    send_item(1'b1, {KIND_NOTE_ON, 4'h9}, 7'd10, 7'd90);
    send_item(1'b1, 8'hFF, 7'd127, 7'd127);
    drain_reports();

    // random traffic with a drain pause and a stretch without idling
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) hot_base = DATA_W'($urandom_range(0, 120));
      if (i == 500) drain_reports();
      calm = (i >= 700 && i < 1000);
      if (i == 850) begin
        // saturate one entry, then step it back down
        for (int k = 0; k < SAT_BURST; k++)
          send_item(1'b0, {KIND_NOTE_ON, 4'h5}, 7'd60, DATA_W'($urandom_range(1, 127)));
        send_item(1'b0, {KIND_NOTE_OFF, 4'h5}, 7'd60, 7'd0);
      end
      send_random_item();
    end
    calm = 1'b0;
    drain_reports();
    repeat (50) @(posedge clk);

    if (sb.mismatches == 0 && sb.waiting() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
